### rtl/core/lsha_pkg.sv
// Shared types, codes and constants for the LED strip heartbeat animator.
// No dependencies; every other file in rtl/core refers to it by scoped name.
package lsha_pkg;

   localparam int STRIP_PIXELS_DEFAULT = 64;

   localparam int TIME_W  = 32;
   localparam int STEP_MS_W = 16;
   localparam int LEVEL_W = 8;
   localparam int PIX_W   = 6;
   localparam int RATE_W  = 8;
   localparam int PHASE_W = 9;

   localparam int DIV_BITS = 16;
   localparam int DIV_CNT_W = $clog2(DIV_BITS);
   localparam logic [DIV_BITS-1:0] BEAT_DIVIDEND = 16'd60000;

   localparam logic [PHASE_W-1:0] TRI_PEAK = 9'd255;
   localparam logic [PHASE_W-1:0] TRI_SPAN = 9'd510;
   localparam logic [PHASE_W-1:0] PHASE_WRAP = 9'd509;

   localparam logic [RATE_W-1:0] BEAT_RATE_RESET = 8'd60;
   localparam logic [STEP_MS_W-1:0] PROGRESS_STEP_RESET = 16'd250;
   localparam logic [STEP_MS_W-1:0] ATTRACT_STEP_RESET = 16'd10;
   localparam logic [LEVEL_W-1:0] FULL_BRIGHTNESS_RESET = 8'd255;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_PROGRESS_STEP = 2'd0;
   localparam logic [1:0] REG_ATTRACT_STEP = 2'd1;
   localparam logic [1:0] REG_FULL_BRIGHTNESS = 2'd2;

   localparam logic [2:0] STATUS_ATTRACT = 3'd0;
   localparam logic [2:0] STATUS_PROGRESS = 3'd1;
   localparam logic [2:0] STATUS_PULSE = 3'd4;

   localparam logic [1:0] ACT_FILL = 2'd0;
   localparam logic [1:0] ACT_PAIR = 2'd1;
   localparam logic [1:0] ACT_BRIGHTNESS = 2'd2;

   typedef enum logic [1:0] {
      MODE_ATTRACT  = 2'd0,
      MODE_PROGRESS = 2'd1,
      MODE_PULSE    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_EVAL   = 2'd2,
      ST_EMIT   = 2'd3
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic [2:0]        status_code;
      logic [RATE_W-1:0] bpm_in;
   } req_type;

   typedef struct packed {
      logic [1:0]         action;
      logic               red_on;
      logic [LEVEL_W-1:0] level;
      logic [PIX_W-1:0]   pixel_low;
      logic [PIX_W-1:0]   pixel_high;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [STEP_MS_W-1:0] progress_step_ms;
      logic [STEP_MS_W-1:0] attract_step_ms;
      logic [LEVEL_W-1:0]   full_brightness;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic eval;
      logic advance;
   } ctrl_cmd_type;

   typedef struct packed {
      logic has_results;
      logic cur_last;
   } ctrl_status_type;

endpackage

### rtl/core/lsha_ctrl.sv
// Sequencer for the animator: accept, divide, evaluate, emit.
// Depends on lsha_pkg; drives the datapath through ctrl_cmd_type.
module lsha_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  lsha_pkg::ctrl_status_type status,
   output lsha_pkg::ctrl_cmd_type    cmd
);

   localparam logic [lsha_pkg::DIV_CNT_W-1:0] DIV_LAST =
      lsha_pkg::DIV_CNT_W'(lsha_pkg::DIV_BITS - 1);

   lsha_pkg::state_type state_ff, state_in;
   logic [lsha_pkg::DIV_CNT_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsha_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         lsha_pkg::ST_IDLE: begin
            step_in = '0;
            if (req_valid) state_in = lsha_pkg::ST_DIVIDE;
         end
         lsha_pkg::ST_DIVIDE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) state_in = lsha_pkg::ST_EVAL;
         end
         lsha_pkg::ST_EVAL: begin
            state_in = status.has_results ? lsha_pkg::ST_EMIT : lsha_pkg::ST_IDLE;
         end
         lsha_pkg::ST_EMIT: begin
            if (!rsp_stall && status.cur_last) state_in = lsha_pkg::ST_IDLE;
         end
         default: state_in = lsha_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      rsp_valid    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         lsha_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         lsha_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
         lsha_pkg::ST_EVAL:   cmd.eval = 1'b1;
         lsha_pkg::ST_EMIT: begin
            rsp_valid   = 1'b1;
            cmd.advance = !rsp_stall;
         end
         default: req_stall = 1'b1;
      endcase
   end

   a_accept_starts_divide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsha_pkg::ST_IDLE && req_valid) |=> state_ff == lsha_pkg::ST_DIVIDE)
      else $error("accepted word did not start the divider");

   a_divide_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsha_pkg::ST_DIVIDE && step_ff == DIV_LAST)
         |=> state_ff == lsha_pkg::ST_EVAL)
      else $error("divider did not finish after its last step");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsha_pkg::ST_EMIT && rsp_stall) |=> state_ff == lsha_pkg::ST_EMIT)
      else $error("left emit while the result word was stalled");

endmodule

### rtl/core/lsha_datapath.sv
// Animator datapath: mode state, bit-serial beat period divider, command buffer.
// Depends on lsha_pkg; steered by lsha_ctrl through ctrl_cmd_type.
module lsha_datapath #(
   parameter int STRIP_PIXELS = lsha_pkg::STRIP_PIXELS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lsha_pkg::ctrl_cmd_type    cmd,
   output lsha_pkg::ctrl_status_type status,
   input  lsha_pkg::cfg_type         cfg,
   input  lsha_pkg::req_type         req_data,
   output lsha_pkg::rsp_type         rsp_data
);

   localparam int CNT_W = $clog2(STRIP_PIXELS + 1);
   localparam int EXT_W = (CNT_W > lsha_pkg::PIX_W) ? CNT_W : lsha_pkg::PIX_W;
   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(STRIP_PIXELS);
   localparam logic [EXT_W-1:0] PIXEL_TOP = EXT_W'(STRIP_PIXELS - 1);
   localparam int T_W = lsha_pkg::TIME_W;
   localparam int Q_W = lsha_pkg::DIV_BITS;
   localparam int R_W = lsha_pkg::RATE_W;

   logic [T_W-1:0] now_ff;
   logic [2:0]     code_ff;
   lsha_pkg::mode_type mode_ff, mode_in;
   logic [lsha_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [T_W-1:0] attract_last_ff, attract_last_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [T_W-1:0] progress_last_ff, progress_last_in;
   logic [T_W-1:0] beat_last_ff, beat_last_in;
   logic [T_W-1:0] flash_start_ff, flash_start_in;
   logic [R_W-1:0] beat_rate_ff, beat_rate_in;
   logic [Q_W-1:0] quo_ff, quo_in;
   logic [R_W-1:0] rem_ff, rem_in;
   lsha_pkg::rsp_type buf_ff [3];
   lsha_pkg::rsp_type buf_in [3];
   logic [1:0] idx_ff, idx_in;

   logic [R_W:0] trial;
   logic [R_W:0] trial_diff;
   logic         trial_ge;

   always_comb begin
      trial      = {rem_ff, quo_ff[Q_W-1]};
      trial_diff = trial - {1'b0, beat_rate_ff};
      trial_ge   = trial >= {1'b0, beat_rate_ff};
   end

   // evaluation signals
   logic start_attract, start_progress, start_pulse, start_any;
   lsha_pkg::mode_type mode_eff;
   logic [lsha_pkg::PHASE_W-1:0] phase_eff;
   logic [T_W-1:0] attract_last_eff, progress_last_eff, beat_last_eff, flash_eff, age;
   logic [CNT_W-1:0] count_eff;
   logic a_due, p_due, b_due;
   logic svc_valid;
   lsha_pkg::rsp_type svc_cmd, black_cmd, bright_cmd;
   logic [EXT_W-1:0] count_ext, mirror_ext;
   logic [1:0] n_results;
   lsha_pkg::rsp_type list [3];

   always_comb begin
      start_attract  = code_ff == lsha_pkg::STATUS_ATTRACT;
      start_progress = code_ff == lsha_pkg::STATUS_PROGRESS;
      start_pulse    = code_ff == lsha_pkg::STATUS_PULSE;
      start_any      = start_attract || start_progress || start_pulse;

      mode_eff = mode_ff;
      if (start_attract) mode_eff = lsha_pkg::MODE_ATTRACT;
      if (start_progress) mode_eff = lsha_pkg::MODE_PROGRESS;
      if (start_pulse) mode_eff = lsha_pkg::MODE_PULSE;

      attract_last_eff  = start_attract ? now_ff : attract_last_ff;
      phase_eff         = start_attract ? '0 : phase_ff;
      progress_last_eff = start_progress ? now_ff : progress_last_ff;
      count_eff         = start_progress ? '0 : count_ff;
      beat_last_eff     = start_pulse ? now_ff : beat_last_ff;

      a_due = (now_ff - attract_last_eff) > T_W'(cfg.attract_step_ms);
      p_due = (now_ff - progress_last_eff) > T_W'(cfg.progress_step_ms);
      b_due = (now_ff - beat_last_eff) > T_W'(quo_ff);

      flash_eff = b_due ? now_ff : flash_start_ff;
      age       = now_ff - flash_eff;

      count_ext  = EXT_W'(count_eff);
      mirror_ext = PIXEL_TOP - count_ext;

      black_cmd  = '{action: lsha_pkg::ACT_FILL, default: '0};
      bright_cmd = '{action: lsha_pkg::ACT_BRIGHTNESS, level: cfg.full_brightness,
                     default: '0};

      svc_valid = 1'b0;
      svc_cmd   = '{action: lsha_pkg::ACT_FILL, red_on: 1'b1, default: '0};
      case (mode_eff)
         lsha_pkg::MODE_ATTRACT: begin
            if (a_due && phase_eff < lsha_pkg::TRI_PEAK) begin
               svc_valid     = 1'b1;
               svc_cmd.level = phase_eff[lsha_pkg::LEVEL_W-1:0];
            end else if (a_due && phase_eff > lsha_pkg::TRI_PEAK) begin
               svc_valid     = 1'b1;
               svc_cmd.level = lsha_pkg::LEVEL_W'(lsha_pkg::TRI_SPAN - phase_eff);
            end
         end
         lsha_pkg::MODE_PROGRESS: begin
            if (p_due && count_eff < COUNT_FULL) begin
               svc_valid          = 1'b1;
               svc_cmd.action     = lsha_pkg::ACT_PAIR;
               svc_cmd.pixel_low  = count_ext[lsha_pkg::PIX_W-1:0];
               svc_cmd.pixel_high = mirror_ext[lsha_pkg::PIX_W-1:0];
            end
         end
         lsha_pkg::MODE_PULSE: begin
            svc_valid = 1'b1;
            if (age < T_W'(lsha_pkg::TRI_PEAK)) begin
               svc_cmd.level = age[lsha_pkg::LEVEL_W-1:0];
            end else if (age > T_W'(lsha_pkg::TRI_PEAK) && age < T_W'(lsha_pkg::TRI_SPAN)) begin
               svc_cmd.level =
                  lsha_pkg::LEVEL_W'(lsha_pkg::TRI_SPAN - age[lsha_pkg::PHASE_W-1:0]);
            end else begin
               svc_cmd.red_on = 1'b0;
            end
         end
         default: svc_valid = 1'b0;
      endcase

      if (start_progress) begin
         list[0]   = black_cmd;
         list[1]   = bright_cmd;
         list[2]   = svc_cmd;
         n_results = 2'd2 + {1'b0, svc_valid};
      end else if (start_any) begin
         list[0]   = black_cmd;
         list[1]   = svc_cmd;
         list[2]   = svc_cmd;
         n_results = 2'd1 + {1'b0, svc_valid};
      end else begin
         list[0]   = svc_cmd;
         list[1]   = svc_cmd;
         list[2]   = svc_cmd;
         n_results = {1'b0, svc_valid};
      end
      for (int i = 0; i < 3; i++) begin
         list[i].last = (2'(i) == n_results - 2'd1);
      end
   end

   always_comb begin
      mode_in          = mode_ff;
      phase_in         = phase_ff;
      attract_last_in  = attract_last_ff;
      count_in         = count_ff;
      progress_last_in = progress_last_ff;
      beat_last_in     = beat_last_ff;
      flash_start_in   = flash_start_ff;
      beat_rate_in     = beat_rate_ff;
      quo_in           = quo_ff;
      rem_in           = rem_ff;
      idx_in           = idx_ff;
      for (int i = 0; i < 3; i++) buf_in[i] = buf_ff[i];

      if (cmd.load) begin
         if (req_data.bpm_in != '0) beat_rate_in = req_data.bpm_in;
         quo_in = lsha_pkg::BEAT_DIVIDEND;
         rem_in = '0;
      end

      if (cmd.div_step) begin
         quo_in = {quo_ff[Q_W-2:0], trial_ge};
         rem_in = trial_ge ? trial_diff[R_W-1:0] : trial[R_W-1:0];
      end

      if (cmd.eval) begin
         mode_in          = mode_eff;
         phase_in         = phase_eff;
         attract_last_in  = attract_last_eff;
         count_in         = count_eff;
         progress_last_in = progress_last_eff;
         beat_last_in     = beat_last_eff;
         case (mode_eff)
            lsha_pkg::MODE_ATTRACT: begin
               if (a_due) begin
                  attract_last_in = now_ff;
                  phase_in = (phase_eff >= lsha_pkg::PHASE_WRAP) ? '0 : phase_eff + 1'b1;
               end
            end
            lsha_pkg::MODE_PROGRESS: begin
               if (p_due) begin
                  progress_last_in = now_ff;
                  if (count_eff < COUNT_FULL) count_in = count_eff + 1'b1;
               end
            end
            lsha_pkg::MODE_PULSE: begin
               if (b_due) begin
                  beat_last_in   = now_ff;
                  flash_start_in = now_ff;
               end
            end
            default: mode_in = mode_eff;
         endcase
         for (int i = 0; i < 3; i++) buf_in[i] = list[i];
         idx_in = '0;
      end

      if (cmd.advance) idx_in = idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= lsha_pkg::MODE_ATTRACT;
         phase_ff         <= '0;
         attract_last_ff  <= '0;
         count_ff         <= '0;
         progress_last_ff <= '0;
         beat_last_ff     <= '0;
         flash_start_ff   <= '0;
         beat_rate_ff     <= lsha_pkg::BEAT_RATE_RESET;
         idx_ff           <= '0;
      end else begin
         mode_ff          <= mode_in;
         phase_ff         <= phase_in;
         attract_last_ff  <= attract_last_in;
         count_ff         <= count_in;
         progress_last_ff <= progress_last_in;
         beat_last_ff     <= beat_last_in;
         flash_start_ff   <= flash_start_in;
         beat_rate_ff     <= beat_rate_in;
         idx_ff           <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff  <= req_data.now_ms;
         code_ff <= req_data.status_code;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      for (int i = 0; i < 3; i++) buf_ff[i] <= buf_in[i];
   end

   always_comb begin
      rsp_data           = buf_ff[idx_ff];
      status.has_results = n_results != 2'd0;
      status.cur_last    = buf_ff[idx_ff].last;
   end

endmodule

### rtl/core/led_strip_heartbeat_animator.sv
// Top level of the LED strip heartbeat animator: configuration registers,
// sequencer and datapath. Depends on lsha_pkg, lsha_ctrl and lsha_datapath.
//
// Each accepted request word yields zero to three strip command words, the
// final one flagged by last. An item is accepted, then the bit-serial
// divider derives the pulse period 60000/bpm, then the mode is evaluated
// and the command buffer filled; command words then go out one per cycle
// while rsp_stall is low. One item is in flight at a time; req_stall
// stays high from acceptance until its last command word is taken, or
// until evaluation if it yields none. Configuration is an APB-style port
// with registers at byte addresses 0, 4 and 8; pready is always high.
module led_strip_heartbeat_animator #(
   parameter int STRIP_PIXELS = lsha_pkg::STRIP_PIXELS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lsha_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lsha_pkg::rsp_type                 rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lsha_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lsha_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lsha_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   lsha_pkg::cfg_type cfg_ff, cfg_in;
   lsha_pkg::ctrl_cmd_type cmd;
   lsha_pkg::ctrl_status_type status;
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            lsha_pkg::REG_PROGRESS_STEP:
               cfg_in.progress_step_ms = csr_pwdata[lsha_pkg::STEP_MS_W-1:0];
            lsha_pkg::REG_ATTRACT_STEP:
               cfg_in.attract_step_ms = csr_pwdata[lsha_pkg::STEP_MS_W-1:0];
            lsha_pkg::REG_FULL_BRIGHTNESS:
               cfg_in.full_brightness = csr_pwdata[lsha_pkg::LEVEL_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         lsha_pkg::REG_PROGRESS_STEP:
            csr_prdata = lsha_pkg::CSR_DATA_W'(cfg_ff.progress_step_ms);
         lsha_pkg::REG_ATTRACT_STEP:
            csr_prdata = lsha_pkg::CSR_DATA_W'(cfg_ff.attract_step_ms);
         lsha_pkg::REG_FULL_BRIGHTNESS:
            csr_prdata = lsha_pkg::CSR_DATA_W'(cfg_ff.full_brightness);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.progress_step_ms <= lsha_pkg::PROGRESS_STEP_RESET;
         cfg_ff.attract_step_ms  <= lsha_pkg::ATTRACT_STEP_RESET;
         cfg_ff.full_brightness  <= lsha_pkg::FULL_BRIGHTNESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lsha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lsha_datapath #(
      .STRIP_PIXELS (STRIP_PIXELS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
